>>> rtl/core/xts_pkg.sv
// xts_pkg: types and constants for the xml token scanner
// holds the scan mode enum, byte roles, token codes and character codes
// no dependencies
package xts_pkg;

   // saturation limit of name and text lengths
   localparam int unsigned LENGTH_LIMIT = 65535;
   localparam int unsigned LEN_W        = 16;

   // scan modes, codes outside the list are treated as between tokens
   typedef enum logic [3:0] {
      MODE_IDLE      = 4'd0,
      MODE_TEXT      = 4'd1,
      MODE_LT        = 4'd2,
      MODE_NAME      = 4'd3,
      MODE_BODY      = 4'd4,
      MODE_DECL      = 4'd5,
      MODE_BANG      = 4'd6,
      MODE_BANGDASH  = 4'd7,
      MODE_COMMENT   = 4'd8
   } scan_mode_type;

   typedef enum logic [1:0] {
      ROLE_MARKUP = 2'd0,
      ROLE_NAME   = 2'd1,
      ROLE_TEXT   = 2'd2
   } byte_role_type;

   typedef enum logic [2:0] {
      DONE_NONE  = 3'd0,
      DONE_START = 3'd1,
      DONE_END   = 3'd2,
      DONE_EMPTY = 3'd3,
      DONE_TEXT  = 3'd4
   } token_done_type;

   // character codes
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_QUEST = 8'h3F;
   localparam logic [7:0] CH_BANG  = 8'h21;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   // whitespace test
   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   // saturating length increment
   function automatic logic [LEN_W-1:0] sat_inc(input logic [LEN_W-1:0] v);
      logic [LEN_W-1:0] lim;
      lim = LEN_W'(LENGTH_LIMIT);
      return (v < lim) ? v + LEN_W'(1) : lim;
   endfunction

endpackage

>>> rtl/core/xml_token_scanner.sv
// xml_token_scanner: byte-serial xml tokenizer, one annotated result per byte
// the result of a request transfer is in the output register in the next cycle
// throughput: one byte per cycle while the receiver is ready; the output register refills in the cycle it drains
// reset (synchronous, active high) clears the scan state and empties the output register
// the scan state also returns to its reset values after a byte marked as last
// depends on xts_pkg
module xml_token_scanner (
   input  logic                     clock,
   input  logic                     reset,
   input  logic [7:0]               req_data_byte,
   input  logic                     req_is_last,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic [7:0]               rsp_byte_echo,
   output logic [1:0]               rsp_byte_role,
   output logic                     rsp_token_begin,
   output logic [2:0]               rsp_token_done,
   output logic [xts_pkg::LEN_W-1:0] rsp_token_length,
   output logic                     rsp_end_of_document,
   input  logic                     rsp_ready,
   output logic                     rsp_valid
);

   // scan state
   xts_pkg::scan_mode_type          mode_ff, mode_in;
   logic [1:0]                      dash_run_ff, dash_run_in;
   logic                            slash_ff, slash_in;
   logic                            closing_ff, closing_in;
   logic [xts_pkg::LEN_W-1:0]       name_cnt_ff, name_cnt_in;
   logic [xts_pkg::LEN_W-1:0]       text_cnt_ff, text_cnt_in;

   // result register
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [7:0]                      echo_ff;
   xts_pkg::byte_role_type          role_ff, role_in;
   logic                            begin_ff, begin_in;
   xts_pkg::token_done_type         done_ff, done_in;
   logic [xts_pkg::LEN_W-1:0]       len_ff, len_in;
   logic                            eod_ff;

   logic                            req_xfer;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_xfer  = req_valid && req_ready;

   // per-byte scan step
   always_comb begin
      logic [7:0] c;
      logic       tag_end;
      c           = req_data_byte;
      tag_end     = 1'b0;
      mode_in     = mode_ff;
      dash_run_in = dash_run_ff;
      slash_in    = slash_ff;
      closing_in  = closing_ff;
      name_cnt_in = name_cnt_ff;
      text_cnt_in = text_cnt_ff;
      role_in     = xts_pkg::ROLE_MARKUP;
      begin_in    = 1'b0;
      done_in     = xts_pkg::DONE_NONE;
      len_in      = '0;

      unique case (mode_ff) inside
         xts_pkg::MODE_TEXT: begin
            if (c == xts_pkg::CH_LT) begin
               done_in     = xts_pkg::DONE_TEXT;
               len_in      = text_cnt_ff;
               text_cnt_in = '0;
               mode_in     = xts_pkg::MODE_LT;
            end else begin
               text_cnt_in = xts_pkg::sat_inc(text_cnt_ff);
               role_in     = xts_pkg::ROLE_TEXT;
            end
         end
         xts_pkg::MODE_LT: begin
            slash_in    = 1'b0;
            name_cnt_in = '0;
            closing_in  = 1'b0;
            if (c == xts_pkg::CH_QUEST) begin
               mode_in = xts_pkg::MODE_DECL;
            end else if (c == xts_pkg::CH_BANG) begin
               mode_in = xts_pkg::MODE_BANG;
            end else if (c == xts_pkg::CH_SLASH) begin
               closing_in = 1'b1;
               mode_in    = xts_pkg::MODE_NAME;
            end else if (c == xts_pkg::CH_GT) begin
               tag_end = 1'b1;
            end else if (xts_pkg::is_ws(c)) begin
               mode_in = xts_pkg::MODE_BODY;
            end else begin
               name_cnt_in = xts_pkg::sat_inc('0);
               role_in     = xts_pkg::ROLE_NAME;
               begin_in    = 1'b1;
               mode_in     = xts_pkg::MODE_NAME;
            end
         end
         xts_pkg::MODE_NAME: begin
            if (c == xts_pkg::CH_GT) begin
               tag_end = 1'b1;
            end else if (c == xts_pkg::CH_SLASH) begin
               slash_in = 1'b1;
               mode_in  = xts_pkg::MODE_BODY;
            end else if (xts_pkg::is_ws(c)) begin
               slash_in = 1'b0;
               mode_in  = xts_pkg::MODE_BODY;
            end else begin
               begin_in    = (name_cnt_ff == '0);
               name_cnt_in = xts_pkg::sat_inc(name_cnt_ff);
               role_in     = xts_pkg::ROLE_NAME;
            end
         end
         xts_pkg::MODE_BODY: begin
            if (c == xts_pkg::CH_GT) begin
               tag_end = 1'b1;
            end else begin
               slash_in = (c == xts_pkg::CH_SLASH);
            end
         end
         xts_pkg::MODE_DECL: begin
            if (c == xts_pkg::CH_GT) begin
               mode_in = xts_pkg::MODE_IDLE;
            end
         end
         xts_pkg::MODE_BANG, xts_pkg::MODE_BANGDASH: begin
            if (c == xts_pkg::CH_DASH) begin
               if (mode_ff == xts_pkg::MODE_BANG) begin
                  mode_in = xts_pkg::MODE_BANGDASH;
               end else begin
                  mode_in     = xts_pkg::MODE_COMMENT;
                  dash_run_in = 2'd0;
               end
            end else if (c == xts_pkg::CH_GT) begin
               mode_in = xts_pkg::MODE_IDLE;
            end else begin
               mode_in = xts_pkg::MODE_DECL;
            end
         end
         xts_pkg::MODE_COMMENT: begin
            if (c == xts_pkg::CH_DASH) begin
               if (dash_run_ff != 2'd2) begin
                  dash_run_in = dash_run_ff + 2'd1;
               end
            end else if (c == xts_pkg::CH_GT && dash_run_ff == 2'd2) begin
               mode_in     = xts_pkg::MODE_IDLE;
               dash_run_in = 2'd0;
            end else begin
               dash_run_in = 2'd0;
            end
         end
         default: begin
            if (c == xts_pkg::CH_LT) begin
               mode_in = xts_pkg::MODE_LT;
            end else if (!xts_pkg::is_ws(c)) begin
               mode_in     = xts_pkg::MODE_TEXT;
               text_cnt_in = xts_pkg::sat_inc('0);
               role_in     = xts_pkg::ROLE_TEXT;
               begin_in    = 1'b1;
            end else begin
               mode_in = xts_pkg::MODE_IDLE;
            end
         end
      endcase

      // tag completion uses the flags as updated by this byte
      if (tag_end) begin
         if (closing_in) begin
            done_in = xts_pkg::DONE_END;
         end else if (slash_in) begin
            done_in = xts_pkg::DONE_EMPTY;
         end else begin
            done_in = xts_pkg::DONE_START;
         end
         len_in      = name_cnt_in;
         mode_in     = xts_pkg::MODE_IDLE;
         slash_in    = 1'b0;
         closing_in  = 1'b0;
         name_cnt_in = '0;
      end

      // last byte flushes open text and restarts the scan
      if (req_is_last) begin
         if (mode_in == xts_pkg::MODE_TEXT && done_in == xts_pkg::DONE_NONE) begin
            done_in = xts_pkg::DONE_TEXT;
            len_in  = text_cnt_in;
         end
         mode_in     = xts_pkg::MODE_IDLE;
         dash_run_in = 2'd0;
         slash_in    = 1'b0;
         closing_in  = 1'b0;
         name_cnt_in = '0;
         text_cnt_in = '0;
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= xts_pkg::MODE_IDLE;
         dash_run_ff  <= 2'd0;
         slash_ff     <= 1'b0;
         closing_ff   <= 1'b0;
         name_cnt_ff  <= '0;
         text_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            mode_ff     <= mode_in;
            dash_run_ff <= dash_run_in;
            slash_ff    <= slash_in;
            closing_ff  <= closing_in;
            name_cnt_ff <= name_cnt_in;
            text_cnt_ff <= text_cnt_in;
         end
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         echo_ff  <= req_data_byte;
         role_ff  <= role_in;
         begin_ff <= begin_in;
         done_ff  <= done_in;
         len_ff   <= len_in;
         eod_ff   <= req_is_last;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_byte_echo       = echo_ff;
   assign rsp_byte_role       = role_ff;
   assign rsp_token_begin     = begin_ff;
   assign rsp_token_done      = done_ff;
   assign rsp_token_length    = len_ff;
   assign rsp_end_of_document = eod_ff;

endmodule

>>> rtl/core/xts_checker.sv
// xts_checker: port-level checks for xml_token_scanner, bound into every xml_token_scanner instance
// depends on xts_pkg and xml_token_scanner
module xts_checker (
   input logic                      clock,
   input logic                      reset,
   input logic [7:0]                req_data_byte,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [7:0]                rsp_byte_echo,
   input logic [1:0]                rsp_byte_role,
   input logic                      rsp_token_begin,
   input logic [2:0]                rsp_token_done,
   input logic [xts_pkg::LEN_W-1:0] rsp_token_length,
   input logic                      rsp_ready,
   input logic                      rsp_valid
);

   // a request transfer shows up as a result in the next cycle with its byte
   a_one_cycle: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid && rsp_byte_echo == $past(req_data_byte))
      else $error("result missing or wrong byte after request transfer");

   // no length without a completed token
   a_len_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_done == xts_pkg::DONE_NONE |-> rsp_token_length == '0)
      else $error("length reported without a token");

   // a token start is always a name or text byte
   a_begin_role: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_begin |-> rsp_byte_role != xts_pkg::ROLE_MARKUP)
      else $error("token start on a markup byte");

   // a text completion never lands on a name byte
   a_text_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_done == xts_pkg::DONE_TEXT |-> rsp_byte_role != xts_pkg::ROLE_NAME)
      else $error("text completion on a name byte");

   // a stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_echo))
      else $error("stalled result changed");

endmodule

bind xml_token_scanner xts_checker u_xts_checker (
   .clock            (clock),
   .reset            (reset),
   .req_data_byte    (req_data_byte),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_byte_echo    (rsp_byte_echo),
   .rsp_byte_role    (rsp_byte_role),
   .rsp_token_begin  (rsp_token_begin),
   .rsp_token_done   (rsp_token_done),
   .rsp_token_length (rsp_token_length),
   .rsp_ready        (rsp_ready),
   .rsp_valid        (rsp_valid)
);

>>> verif/xml_token_scanner_test.sv
// xml_token_scanner_test: self-checking testbench for the byte-serial xml tokenizer
// predicts the annotation of every accepted byte and compares each result transfer
// depends on xts_pkg and xml_token_scanner
module xml_token_scanner_test;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD = 10;
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_BYTES = 1200;
   localparam int TOKEN_RUN    = 100;

   typedef struct {
      logic [7:0]                byte_echo;
      xts_pkg::byte_role_type    byte_role;
      logic                      token_begin;
      xts_pkg::token_done_type   token_done;
      logic [xts_pkg::LEN_W-1:0] token_length;
      logic                      end_of_document;
   } byte_annotation_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic [7:0]                req_data_byte = '0;
   logic                      req_is_last = 1'b0;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [7:0]                rsp_byte_echo;
   logic [1:0]                rsp_byte_role;
   logic                      rsp_token_begin;
   logic [2:0]                rsp_token_done;
   logic [xts_pkg::LEN_W-1:0] rsp_token_length;
   logic                      rsp_end_of_document;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_valid;

   // scanner state as seen by the predictor
   xts_pkg::scan_mode_type    tok_mode;
   logic [1:0]                dash_seen;
   logic                      slash_seen;
   logic                      closing_tag;
   logic [xts_pkg::LEN_W-1:0] name_len;
   logic [xts_pkg::LEN_W-1:0] text_len;

   byte_annotation_type pending_annotations[$];
   logic [7:0]          doc_bytes[$];
   logic                gaps_on = 1'b1;
   int                  mismatch_count = 0;
   int                  quiet_cycles = 0;

   xml_token_scanner DUT (
      .clock               (clock),
      .reset               (reset),
      .req_data_byte       (req_data_byte),
      .req_is_last         (req_is_last),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .rsp_byte_echo       (rsp_byte_echo),
      .rsp_byte_role       (rsp_byte_role),
      .rsp_token_begin     (rsp_token_begin),
      .rsp_token_done      (rsp_token_done),
      .rsp_token_length    (rsp_token_length),
      .rsp_end_of_document (rsp_end_of_document),
      .rsp_ready           (rsp_ready),
      .rsp_valid           (rsp_valid)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   function automatic logic blank_char(input logic [7:0] c);
      return c == xts_pkg::CH_SPACE || c == xts_pkg::CH_TAB || c == xts_pkg::CH_LF ||
             c == xts_pkg::CH_CR;
   endfunction

   function automatic logic [xts_pkg::LEN_W-1:0] grow_len(
      input logic [xts_pkg::LEN_W-1:0] n);
      return (n < xts_pkg::LEN_W'(xts_pkg::LENGTH_LIMIT)) ?
             n + 1'b1 : xts_pkg::LEN_W'(xts_pkg::LENGTH_LIMIT);
   endfunction

   function automatic void clear_scan_state();
      tok_mode    = xts_pkg::MODE_IDLE;
      dash_seen   = '0;
      slash_seen  = 1'b0;
      closing_tag = 1'b0;
      name_len    = '0;
      text_len    = '0;
   endfunction

   // a tag completes on its closing bracket
   function automatic void close_tag(output xts_pkg::token_done_type done,
                                     output logic [xts_pkg::LEN_W-1:0] len);
      if (closing_tag)
         done = xts_pkg::DONE_END;
      else
         done = slash_seen ? xts_pkg::DONE_EMPTY : xts_pkg::DONE_START;
      len         = name_len;
      tok_mode    = xts_pkg::MODE_IDLE;
      slash_seen  = 1'b0;
      closing_tag = 1'b0;
      name_len    = '0;
   endfunction

   function automatic byte_annotation_type annotate_byte(input logic [7:0] c,
                                                         input logic last);
      byte_annotation_type a;
      a.byte_echo       = c;
      a.byte_role       = xts_pkg::ROLE_MARKUP;
      a.token_begin     = 1'b0;
      a.token_done      = xts_pkg::DONE_NONE;
      a.token_length    = '0;
      a.end_of_document = last;
      case (tok_mode)
         xts_pkg::MODE_TEXT: begin
            if (c == xts_pkg::CH_LT) begin
               a.token_done   = xts_pkg::DONE_TEXT;
               a.token_length = text_len;
               text_len       = '0;
               tok_mode       = xts_pkg::MODE_LT;
            end else begin
               text_len    = grow_len(text_len);
               a.byte_role = xts_pkg::ROLE_TEXT;
            end
         end
         xts_pkg::MODE_LT: begin
            slash_seen  = 1'b0;
            name_len    = '0;
            closing_tag = 1'b0;
            if (c == xts_pkg::CH_QUEST) begin
               tok_mode = xts_pkg::MODE_DECL;
            end else if (c == xts_pkg::CH_BANG) begin
               tok_mode = xts_pkg::MODE_BANG;
            end else if (c == xts_pkg::CH_SLASH) begin
               closing_tag = 1'b1;
               tok_mode    = xts_pkg::MODE_NAME;
            end else if (c == xts_pkg::CH_GT) begin
               close_tag(a.token_done, a.token_length);
            end else if (blank_char(c)) begin
               tok_mode = xts_pkg::MODE_BODY;
            end else begin
               name_len      = grow_len('0);
               a.byte_role   = xts_pkg::ROLE_NAME;
               a.token_begin = 1'b1;
               tok_mode      = xts_pkg::MODE_NAME;
            end
         end
         xts_pkg::MODE_NAME: begin
            if (c == xts_pkg::CH_GT) begin
               close_tag(a.token_done, a.token_length);
            end else if (c == xts_pkg::CH_SLASH) begin
               slash_seen = 1'b1;
               tok_mode   = xts_pkg::MODE_BODY;
            end else if (blank_char(c)) begin
               slash_seen = 1'b0;
               tok_mode   = xts_pkg::MODE_BODY;
            end else begin
               // first name byte of an end tag comes after the slash
               if (name_len == '0)
                  a.token_begin = 1'b1;
               name_len    = grow_len(name_len);
               a.byte_role = xts_pkg::ROLE_NAME;
            end
         end
         xts_pkg::MODE_BODY: begin
            if (c == xts_pkg::CH_GT)
               close_tag(a.token_done, a.token_length);
            else
               slash_seen = (c == xts_pkg::CH_SLASH);
         end
         xts_pkg::MODE_DECL: begin
            if (c == xts_pkg::CH_GT)
               tok_mode = xts_pkg::MODE_IDLE;
         end
         xts_pkg::MODE_BANG: begin
            if (c == xts_pkg::CH_DASH)
               tok_mode = xts_pkg::MODE_BANGDASH;
            else
               tok_mode = (c == xts_pkg::CH_GT) ? xts_pkg::MODE_IDLE : xts_pkg::MODE_DECL;
         end
         xts_pkg::MODE_BANGDASH: begin
            if (c == xts_pkg::CH_DASH) begin
               tok_mode  = xts_pkg::MODE_COMMENT;
               dash_seen = '0;
            end else begin
               tok_mode = (c == xts_pkg::CH_GT) ? xts_pkg::MODE_IDLE : xts_pkg::MODE_DECL;
            end
         end
         xts_pkg::MODE_COMMENT: begin
            // a comment closes on two dashes followed by a bracket
            if (c == xts_pkg::CH_DASH) begin
               if (dash_seen < 2'd2)
                  dash_seen = dash_seen + 1'b1;
            end else if (c == xts_pkg::CH_GT && dash_seen == 2'd2) begin
               tok_mode  = xts_pkg::MODE_IDLE;
               dash_seen = '0;
            end else begin
               dash_seen = '0;
            end
         end
         default: begin
            if (c == xts_pkg::CH_LT) begin
               tok_mode = xts_pkg::MODE_LT;
            end else if (!blank_char(c)) begin
               tok_mode      = xts_pkg::MODE_TEXT;
               text_len      = grow_len('0);
               a.byte_role   = xts_pkg::ROLE_TEXT;
               a.token_begin = 1'b1;
            end else begin
               tok_mode = xts_pkg::MODE_IDLE;
            end
         end
      endcase
      // the last byte flushes pending text and restarts the scanner
      if (last) begin
         if (tok_mode == xts_pkg::MODE_TEXT && a.token_done == xts_pkg::DONE_NONE) begin
            a.token_done   = xts_pkg::DONE_TEXT;
            a.token_length = text_len;
         end
         clear_scan_state();
      end
      return a;
   endfunction

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------

   function automatic logic [7:0] any_byte_but(input logic [7:0] skip);
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == skip);
      return b;
   endfunction

   function automatic logic [7:0] blank_byte();
      case ($urandom_range(3))
         0: return xts_pkg::CH_SPACE;
         1: return xts_pkg::CH_TAB;
         2: return xts_pkg::CH_LF;
         default: return xts_pkg::CH_CR;
      endcase
   endfunction

   function automatic logic [7:0] name_byte();
      logic [7:0] b;
      do
         b = 8'($urandom_range(255));
      while (b == xts_pkg::CH_GT || b == xts_pkg::CH_SLASH || b == xts_pkg::CH_LT ||
             blank_char(b));
      return b;
   endfunction

   // random document: mostly well-formed pieces, some noise and cut-off endings
   function automatic void build_document();
      logic [7:0] markup_chars[6];
      int         parts;
      int         cut;
      markup_chars = '{xts_pkg::CH_LT, xts_pkg::CH_GT, xts_pkg::CH_SLASH,
                       xts_pkg::CH_QUEST, xts_pkg::CH_BANG, xts_pkg::CH_DASH};
      parts = $urandom_range(1, 8);
      doc_bytes.delete();
      repeat (parts) begin
         case ($urandom_range(9)) inside
            0, 1: begin
               repeat ($urandom_range(0, 3)) doc_bytes.push_back(blank_byte());
               repeat ($urandom_range(1, 10))
                  doc_bytes.push_back(any_byte_but(xts_pkg::CH_LT));
            end
            2: begin
               repeat ($urandom_range(1, 4)) doc_bytes.push_back(blank_byte());
            end
            3, 4: begin
               doc_bytes.push_back(xts_pkg::CH_LT);
               repeat ($urandom_range(1, 6)) doc_bytes.push_back(name_byte());
               if ($urandom_range(1)) begin
                  doc_bytes.push_back(blank_byte());
                  repeat ($urandom_range(0, 6))
                     doc_bytes.push_back(any_byte_but(xts_pkg::CH_GT));
               end
               if ($urandom_range(2) == 0)
                  doc_bytes.push_back(xts_pkg::CH_SLASH);
               doc_bytes.push_back(xts_pkg::CH_GT);
            end
            5: begin
               doc_bytes.push_back(xts_pkg::CH_LT);
               doc_bytes.push_back(xts_pkg::CH_SLASH);
               repeat ($urandom_range(0, 6)) doc_bytes.push_back(name_byte());
               case ($urandom_range(2))
                  0: doc_bytes.push_back(blank_byte());
                  1: doc_bytes.push_back(xts_pkg::CH_SLASH);
                  default: ;
               endcase
               doc_bytes.push_back(xts_pkg::CH_GT);
            end
            6: begin
               doc_bytes.push_back(xts_pkg::CH_LT);
               doc_bytes.push_back(xts_pkg::CH_BANG);
               doc_bytes.push_back(xts_pkg::CH_DASH);
               doc_bytes.push_back(xts_pkg::CH_DASH);
               repeat ($urandom_range(0, 8)) begin
                  case ($urandom_range(2))
                     0: doc_bytes.push_back(xts_pkg::CH_DASH);
                     1: doc_bytes.push_back(xts_pkg::CH_GT);
                     default: doc_bytes.push_back(8'($urandom_range(255)));
                  endcase
               end
               doc_bytes.push_back(xts_pkg::CH_DASH);
               doc_bytes.push_back(xts_pkg::CH_DASH);
               doc_bytes.push_back(xts_pkg::CH_GT);
            end
            7: begin
               doc_bytes.push_back(xts_pkg::CH_LT);
               doc_bytes.push_back($urandom_range(1) ? xts_pkg::CH_QUEST : xts_pkg::CH_BANG);
               repeat ($urandom_range(0, 6))
                  doc_bytes.push_back(any_byte_but(xts_pkg::CH_GT));
               doc_bytes.push_back(xts_pkg::CH_GT);
            end
            8: begin
               repeat ($urandom_range(1, 4)) doc_bytes.push_back(8'($urandom_range(255)));
            end
            default: begin
               repeat ($urandom_range(1, 5))
                  doc_bytes.push_back(markup_chars[$urandom_range(5)]);
            end
         endcase
      end
      // some documents end in the middle of a token
      if ($urandom_range(4) == 0) begin
         cut = $urandom_range(1, doc_bytes.size());
         while (doc_bytes.size() > cut) void'(doc_bytes.pop_back());
      end
   endfunction

   // one byte transfer on the request channel, predicted when accepted
   task automatic send_byte(input logic [7:0] value, input logic last);
      while (gaps_on && $urandom_range(99) < 32) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_data_byte <= value;
      req_is_last   <= last;
      do
         @(posedge clock);
      while (!req_ready);
      pending_annotations.push_back(annotate_byte(value, last));
   endtask

   task automatic send_document();
      foreach (doc_bytes[i])
         send_byte(doc_bytes[i], i == doc_bytes.size() - 1);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // tags, text ended by a bracket and by the last byte, empty names, byte extremes
   task automatic test_markup_tokens();
      doc_bytes = '{xts_pkg::CH_TAB, xts_pkg::CH_LT, "a", xts_pkg::CH_GT, 8'hFF, 8'h00,
                    xts_pkg::CH_LT, xts_pkg::CH_SLASH, "a", xts_pkg::CH_SLASH,
                    xts_pkg::CH_GT, xts_pkg::CH_LT, xts_pkg::CH_GT, xts_pkg::CH_LT,
                    xts_pkg::CH_SPACE, "b", xts_pkg::CH_SLASH, xts_pkg::CH_GT, "z"};
      send_document();
   endtask

   // comments, declarations, an unterminated tag and the restart after it
   task automatic test_skipped_markup();
      doc_bytes = '{xts_pkg::CH_LT, xts_pkg::CH_BANG, xts_pkg::CH_DASH, xts_pkg::CH_DASH,
                    xts_pkg::CH_GT, xts_pkg::CH_DASH, xts_pkg::CH_DASH, xts_pkg::CH_GT,
                    xts_pkg::CH_LT, xts_pkg::CH_QUEST, "x", xts_pkg::CH_GT,
                    xts_pkg::CH_LT, "q"};
      send_document();
      doc_bytes = '{"r"};
      send_document();
   endtask

   // long text run and long end tag name, no idling
   task automatic test_long_tokens();
      gaps_on <= 1'b0;
      doc_bytes.delete();
      doc_bytes.push_back(name_byte());
      repeat (TOKEN_RUN - 1) doc_bytes.push_back(any_byte_but(xts_pkg::CH_LT));
      doc_bytes.push_back(xts_pkg::CH_LT);
      doc_bytes.push_back(xts_pkg::CH_SLASH);
      repeat (TOKEN_RUN) doc_bytes.push_back(name_byte());
      doc_bytes.push_back(xts_pkg::CH_GT);
      send_document();
   endtask

   task automatic test_random_documents();
      int sent;
      sent = 0;
      while (sent < RANDOM_BYTES) begin
         // a stretch in the middle runs without idling on either side
         gaps_on <= !(sent >= 500 && sent < 800);
         build_document();
         if (doc_bytes.size() != 0) begin
            send_document();
            sent += doc_bytes.size();
         end
      end
      gaps_on <= 1'b1;
   endtask

   // ------------------------------------------------------------------
   // result checking
   // ------------------------------------------------------------------

   function automatic void check_field(input string field,
                                       input logic [xts_pkg::LEN_W-1:0] want,
                                       input logic [xts_pkg::LEN_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         mismatch_count++;
      end
   endfunction

   // compare each result transfer with the oldest prediction
   always @(posedge clock) begin
      byte_annotation_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_annotations.size() == 0) begin
            $error("result transfer with no byte outstanding, byte_echo %0d", rsp_byte_echo);
            mismatch_count++;
         end else begin
            want = pending_annotations.pop_front();
            check_field("byte_echo", xts_pkg::LEN_W'(want.byte_echo),
                        xts_pkg::LEN_W'(rsp_byte_echo));
            check_field("byte_role", xts_pkg::LEN_W'(want.byte_role),
                        xts_pkg::LEN_W'(rsp_byte_role));
            check_field("token_begin", xts_pkg::LEN_W'(want.token_begin),
                        xts_pkg::LEN_W'(rsp_token_begin));
            check_field("token_done", xts_pkg::LEN_W'(want.token_done),
                        xts_pkg::LEN_W'(rsp_token_done));
            check_field("token_length", want.token_length, rsp_token_length);
            check_field("end_of_document", xts_pkg::LEN_W'(want.end_of_document),
                        xts_pkg::LEN_W'(rsp_end_of_document));
         end
      end
   end

   // receiver stalls
   always @(posedge clock) begin
      rsp_ready <= !gaps_on || ($urandom_range(99) >= 32);
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      clear_scan_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_markup_tokens();
      test_skipped_markup();
      test_long_tokens();
      test_random_documents();
      req_valid <= 1'b0;
      while (pending_annotations.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
